/* hw/rtl/gaussian_random_generator_unit_defines.svh */
// assertion macros for the gaussian random generator
`ifndef GAUSSIAN_RANDOM_GENERATOR_UNIT_DEFINES_SVH
`define GAUSSIAN_RANDOM_GENERATOR_UNIT_DEFINES_SVH
// implication checked on every clock edge outside reset
`define GRG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication checked outside reset
`define GRG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* hw/rtl/grg_pkg.sv */
// shared types and constants of the gaussian random generator
package grg_pkg;
    typedef struct packed {
        logic        func;
        logic        want_pair;
        logic [31:0] mean_shift;
        logic [31:0] spread;
    } t_req;

    typedef struct packed {
        logic [31:0] normal_value;
        logic [23:0] uniform_value;
        logic        last;
    } t_res;

    // classified request between front and back
    typedef struct packed {
        logic        func;
        logic        want_pair;
        logic [31:0] mean_shift;
        logic [31:0] spread;
        logic [23:0] u1;
        logic [23:0] u2;
    } t_job;

    localparam logic        FUNC_UNIFORM = 1'b0;
    localparam logic        FUNC_NORMAL  = 1'b1;
    localparam logic [63:0] LCG_MULT     = 64'd6364136223846793005;
    localparam logic [31:0] LN2_Q32      = 32'd2977044472;
    localparam logic [31:0] TWO_PI_Q28   = 32'd1686629713;
    localparam logic [31:0] Q30_ONE      = 32'd1073741824;
    localparam logic [23:0] U_MIN        = 24'd2;
    localparam logic [23:0] U_MAX        = 24'd16777214;
    localparam logic        REG_SEED     = 1'b0;
    localparam logic        REG_INC      = 1'b1;

    function automatic logic [23:0] f_clamp(input logic [31:0] w);
        logic [23:0] v;
        v = w[31:8];
        if (v < U_MIN) v = U_MIN;
        if (v > U_MAX) v = U_MAX;
        return v;
    endfunction

    function automatic logic [31:0] f_out(input logic [63:0] old);
        logic [63:0] t;
        logic [31:0] xs;
        logic [4:0]  rot;
        t   = ((old >> 18) ^ old) >> 27;
        xs  = t[31:0];
        rot = old[63:59];
        return (xs >> rot) | (xs << ((6'd32 - {1'b0, rot}) & 6'd31));
    endfunction
endpackage

/* hw/rtl/grg_front.sv */
// front part: generator steps and request classification
module grg_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  grg_pkg::t_req   i_req,
    input  logic            i_seed_we,
    input  logic [63:0]     i_seed,
    input  logic [63:0]     i_inc,
    output logic            o_job_valid,
    input  logic            i_job_ready,
    output grg_pkg::t_job   o_job
);
    import grg_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]  r_st, n_st;
    logic [63:0] r_pcg;
    logic [63:0] r_lo, r_hi;   // split multiply partials
    logic        r_second;
    logic        r_half;
    t_job        r_job;

    assign o_ready     = (r_st == S_IDLE) && !i_seed_we;
    assign o_job_valid = (r_st == S_OUT);
    assign o_job       = r_job;

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE:  if (i_valid && o_ready) n_st = S_MUL;
            S_MUL:   if (r_half && !(r_job.func == FUNC_NORMAL && !r_second)) n_st = S_OUT;
            S_OUT:   if (i_job_ready) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_pcg    <= 64'd0;
            r_second <= 1'b0;
            r_half   <= 1'b0;
        end else begin
            r_st <= n_st;
            if (i_seed_we) begin
                r_pcg <= i_seed;
            end else if (r_st == S_IDLE && i_valid) begin
                r_half   <= 1'b0;
                r_second <= 1'b0;
                r_job.func       <= i_req.func;
                r_job.want_pair  <= i_req.want_pair;
                r_job.mean_shift <= i_req.mean_shift;
                r_job.spread     <= i_req.spread;
                r_job.u1         <= f_clamp(f_out(r_pcg));
                r_job.u2         <= 24'd0;
                r_lo <= {32'd0, r_pcg[31:0]} * {32'd0, LCG_MULT[31:0]};
                r_hi <= 64'(r_pcg[63:32] * LCG_MULT[31:0])
                      + 64'(r_pcg[31:0] * LCG_MULT[63:32]);
            end else if (r_st == S_MUL) begin
                if (!r_half) begin
                    r_half <= 1'b1;
                    r_pcg  <= r_lo + {r_hi[31:0], 32'd0} + i_inc;
                end else begin
                    r_half <= 1'b0;
                    if (r_job.func == FUNC_NORMAL && !r_second) begin
                        r_second <= 1'b1;
                        r_job.u2 <= f_clamp(f_out(r_pcg));
                        r_lo <= {32'd0, r_pcg[31:0]} * {32'd0, LCG_MULT[31:0]};
                        r_hi <= 64'(r_pcg[63:32] * LCG_MULT[31:0])
                              + 64'(r_pcg[31:0] * LCG_MULT[63:32]);
                    end
                end
            end
        end
    end
endmodule

/* hw/rtl/grg_queue.sv */
// two-entry queue between front and back
module grg_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  grg_pkg::t_job i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output grg_pkg::t_job o_data
);
    import grg_pkg::*;
    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_valid && o_ready) begin
                r_mem[r_wp] <= i_data;
                r_wp <= ~r_wp;
            end
            if (o_valid && i_ready) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_valid && o_ready) - 2'(o_valid && i_ready);
        end
    end
endmodule

/* hw/rtl/grg_back.sv */
// back part: box-muller transform sequencer, uniform pass-through and output register
module grg_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  grg_pkg::t_job i_job,
    output logic          o_valid,
    input  logic          i_ready,
    output grg_pkg::t_res o_res,
    output logic          o_busy
);
    import grg_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LOG  = 4'd1;
    localparam logic [3:0] S_LN   = 4'd2;
    localparam logic [3:0] S_SQRT = 4'd3;
    localparam logic [3:0] S_ANG  = 4'd4;
    localparam logic [3:0] S_X2   = 4'd5;
    localparam logic [3:0] S_SER  = 4'd6;
    localparam logic [3:0] S_SIN  = 4'd7;
    localparam logic [3:0] S_MAG  = 4'd8;
    localparam logic [3:0] S_SCL  = 4'd9;
    localparam logic [3:0] S_ADD  = 4'd10;
    localparam logic [3:0] S_EMIT = 4'd11;
    localparam logic [3:0] S_DIV  = 4'd12;

    logic [3:0]  r_st;
    t_job        r_job;
    logic [4:0]  r_p;
    logic [4:0]  r_i;
    logic [31:0] r_x;        // q2.30 squaring value
    logic [23:0] r_frac;
    logic [63:0] r_w;        // sqrt remainder
    logic [63:0] r_res;
    logic [63:0] r_bit;
    logic [31:0] r_r;        // radius q.24
    logic [2:0]  r_oct;
    logic [31:0] r_ang;
    logic [31:0] r_x2;
    logic [31:0] r_h;
    logic [31:0] r_hx;
    logic [31:0] r_s0, r_c0;
    logic        r_cos_done; // series phase: 0 sine, 1 cosine
    logic        r_second;   // emitting sine variate
    logic [31:0] r_mag;
    logic signed [63:0] r_prod;
    t_res        r_out;
    logic        r_ov;

    logic [31:0] trig_sel;
    logic        trig_neg;
    logic [4:0]  m_p;
    logic [63:0] sq;
    logic [30:0] rcp_m;
    logic [5:0]  rcp_k;
    logic [31:0] hx;
    logic [63:0] hprod;
    logic [31:0] hq;
    logic [63:0] trial;
    logic signed [63:0] q_sum;

    assign o_ready = (r_st == S_IDLE);
    assign o_valid = r_ov;
    assign o_res   = r_out;
    assign o_busy  = (r_st != S_IDLE) || r_ov;

    always_comb begin
        m_p = 5'd0;
        for (int k = 1; k < 24; k++) if (i_job.u1[k]) m_p = 5'(k);
    end

    always_comb begin
        trig_sel = 32'd0; trig_neg = 1'b0;
        case ({r_second, r_oct})
            4'd0: begin trig_sel = r_c0; end
            4'd1: begin trig_sel = r_s0; end
            4'd2: begin trig_sel = r_s0; trig_neg = 1'b1; end
            4'd3: begin trig_sel = r_c0; trig_neg = 1'b1; end
            4'd4: begin trig_sel = r_c0; trig_neg = 1'b1; end
            4'd5: begin trig_sel = r_s0; trig_neg = 1'b1; end
            4'd6: begin trig_sel = r_s0; end
            4'd7: begin trig_sel = r_c0; end
            4'd8: begin trig_sel = r_s0; end
            4'd9: begin trig_sel = r_c0; end
            4'd10: begin trig_sel = r_c0; end
            4'd11: begin trig_sel = r_s0; end
            4'd12: begin trig_sel = r_s0; trig_neg = 1'b1; end
            4'd13: begin trig_sel = r_c0; trig_neg = 1'b1; end
            4'd14: begin trig_sel = r_c0; trig_neg = 1'b1; end
            default: begin trig_sel = r_s0; trig_neg = 1'b1; end
        endcase
    end

    // horner divisors: sine 110 72 42 20 6, cosine 132 90 56 30 12 2
    // as reciprocal multiply and shift, exact for dividends below 2^30
    always_comb begin
        rcp_m = 31'd1073741824;
        rcp_k = 6'd31;
        if (!r_cos_done) begin
            case (r_i)
                5'd0: begin rcp_m = 31'd1249445032; rcp_k = 6'd37; end
                5'd1: begin rcp_m = 31'd1908874354; rcp_k = 6'd37; end
                5'd2: begin rcp_m = 31'd1636178018; rcp_k = 6'd36; end
                5'd3: begin rcp_m = 31'd1717986919; rcp_k = 6'd35; end
                default: begin rcp_m = 31'd1431655766; rcp_k = 6'd33; end
            endcase
        end else begin
            case (r_i)
                5'd0: begin rcp_m = 31'd2082408386; rcp_k = 6'd38; end
                5'd1: begin rcp_m = 31'd1527099484; rcp_k = 6'd37; end
                5'd2: begin rcp_m = 31'd1227133514; rcp_k = 6'd36; end
                5'd3: begin rcp_m = 31'd1145324613; rcp_k = 6'd35; end
                5'd4: begin rcp_m = 31'd1431655766; rcp_k = 6'd34; end
                default: begin rcp_m = 31'd1073741824; rcp_k = 6'd31; end
            endcase
        end
    end

    assign sq    = {32'd0, r_x} * {32'd0, r_x};
    assign hx    = 32'(({32'd0, r_x2} * {32'd0, r_h}) >> 30);
    assign hprod = {32'd0, r_hx} * {33'd0, rcp_m};
    assign hq    = 32'(hprod >> rcp_k);
    assign trial = r_res + r_bit;
    assign q_sum = (r_prod >>> 16)
                 + $signed({{32{r_job.mean_shift[31]}}, r_job.mean_shift});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ov <= 1'b0;
        end else begin
            if (r_ov && i_ready) r_ov <= 1'b0;
            unique case (r_st)
                S_IDLE: if (i_valid) begin
                    r_job <= i_job;
                    r_second <= 1'b0;
                    if (i_job.func == FUNC_UNIFORM) begin
                        r_st <= S_EMIT;
                    end else begin
                        r_p    <= m_p;
                        r_x    <= 32'({8'd0, i_job.u1} << (5'd30 - m_p));
                        r_frac <= 24'd0;
                        r_i    <= 5'd23;
                        r_st   <= S_LOG;
                    end
                end
                S_LOG: begin
                    if (sq[61:30] >= 32'h8000_0000) begin
                        r_x <= sq[62:31];
                        r_frac[r_i] <= 1'b1;
                    end else begin
                        r_x <= sq[61:30];
                    end
                    if (r_i == 5'd0) r_st <= S_LN;
                    else r_i <= r_i - 5'd1;
                end
                S_LN: begin
                    r_w <= ((((({35'd0, 5'd24 - r_p, 24'd0} - {40'd0, r_frac})
                            * {32'd0, LN2_Q32}) + 64'd1073741824) >> 31) << 24);
                    r_res <= 64'd0;
                    r_bit <= 64'd1 << 62;
                    r_st  <= S_SQRT;
                end
                S_SQRT: begin
                    if (r_bit == 64'd0) begin
                        r_r  <= r_res[31:0];
                        r_st <= S_ANG;
                    end else begin
                        r_bit <= r_bit >> 2;
                        if (r_w >= trial) begin
                            r_w   <= r_w - trial;
                            r_res <= (r_res >> 1) + r_bit;
                        end else begin
                            r_res <= r_res >> 1;
                        end
                    end
                end
                S_ANG: begin
                    r_oct <= r_job.u2[23:21];
                    r_ang <= 32'((({42'd0, (r_job.u2[21] ? 22'h200000
                            - {1'b0, r_job.u2[20:0]} : {1'b0, r_job.u2[20:0]})})
                            * {32'd0, TWO_PI_Q28}) >> 22);
                    r_st <= S_X2;
                end
                S_X2: begin
                    r_x2 <= 32'(({32'd0, r_ang} * {32'd0, r_ang}) >> 30);
                    r_h  <= Q30_ONE;
                    r_i  <= 5'd0;
                    r_cos_done <= 1'b0;
                    r_st <= S_SER;
                end
                S_SER: begin
                    r_hx <= hx;
                    r_st <= S_DIV;
                end
                S_DIV: begin
                    r_h <= Q30_ONE - hq;
                    if (!r_cos_done && r_i == 5'd4) begin
                        r_st <= S_SIN;
                    end else if (r_cos_done && r_i == 5'd5) begin
                        r_c0 <= Q30_ONE - hq;
                        r_st <= S_MAG;
                    end else begin
                        r_i  <= r_i + 5'd1;
                        r_st <= S_SER;
                    end
                end
                S_SIN: begin
                    r_s0 <= 32'(({32'd0, r_ang} * {32'd0, r_h}) >> 30);
                    r_h  <= Q30_ONE;
                    r_i  <= 5'd0;
                    r_cos_done <= 1'b1;
                    r_st <= S_SER;
                end
                S_MAG: begin
                    r_mag <= 32'(({32'd0, r_r} * {32'd0, trig_sel}) >> 38);
                    r_st  <= S_SCL;
                end
                S_SCL: begin
                    r_prod <= $signed({{32{r_job.spread[31]}}, r_job.spread})
                            * (trig_neg ? -$signed({32'd0, r_mag})
                                        : $signed({32'd0, r_mag}));
                    r_st <= S_ADD;
                end
                S_ADD: if (!r_ov) begin
                    if (q_sum > 64'sd2147483647) r_out.normal_value <= 32'h7fff_ffff;
                    else if (q_sum < -64'sd2147483648) r_out.normal_value <= 32'h8000_0000;
                    else r_out.normal_value <= q_sum[31:0];
                    r_out.uniform_value <= 24'd0;
                    r_out.last <= r_second || !r_job.want_pair;
                    r_ov <= 1'b1;
                    if (!r_second && r_job.want_pair) begin
                        r_second <= 1'b1;
                        r_st <= S_MAG;
                    end else begin
                        r_st <= S_IDLE;
                    end
                end
                S_EMIT: if (!r_ov) begin
                    r_out.normal_value  <= 32'd0;
                    r_out.uniform_value <= r_job.u1;
                    r_out.last          <= 1'b1;
                    r_ov <= 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

/* hw/rtl/gaussian_random_generator_unit.sv */
// top level of the gaussian random generator
// The front takes one generator step for a uniform request and two for a
// normal one, each a split 64-bit multiply: partials registered, then summed
// with the increment into the new state. In the back a normal request runs 24
// log squarings, the square root loop and the series (a multiply and a divide
// state per term), then the magnitude, scale and add states to its cosine
// word; the sine word of a pair passes magnitude, scale and add again. A
// uniform request goes from idle to the emit state. Registers: seed_state at
// 0x00, stream_increment at 0x08; writing the seed reloads the generator.
`include "gaussian_random_generator_unit_defines.svh"
module gaussian_random_generator_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  grg_pkg::t_req  i_req,
    output logic           o_valid,
    input  logic           i_ready,
    output grg_pkg::t_res  o_res,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [3:0]     paddr,
    input  logic [63:0]    pwdata,
    output logic [63:0]    prdata,
    output logic           pready
);
    import grg_pkg::*;

    logic [63:0] r_seed, r_inc;
    logic        wr, seed_we;
    logic        jv, jr, qv, qr, busy;
    t_job        job, qjob;

    assign pready  = 1'b1;
    assign wr      = psel && penable && pwrite;
    assign seed_we = wr && (paddr[3] == REG_SEED) && (paddr[2:0] == 3'd0);
    assign prdata  = (paddr[3] == REG_INC) ? r_inc : r_seed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= 64'd0;
            r_inc  <= 64'd1;
        end else if (wr && paddr[2:0] == 3'd0) begin
            if (paddr[3] == REG_SEED) r_seed <= pwdata;
            else r_inc <= pwdata;
        end
    end

    grg_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_req,
        .i_seed_we(seed_we), .i_seed(pwdata), .i_inc(r_inc),
        .o_job_valid(jv), .i_job_ready(jr), .o_job(job)
    );
    grg_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(jv), .o_ready(jr), .i_data(job),
        .o_valid(qv), .i_ready(qr), .o_data(qjob)
    );
    grg_back u_back (
        .i_clk, .i_rst_n, .i_valid(qv), .o_ready(qr), .i_job(qjob),
        .o_valid, .i_ready, .o_res, .o_busy(busy)
    );

    `GRG_ASSERT_IMP(a_uni_last, i_clk, i_rst_n,
        o_valid && o_res.uniform_value != 24'd0, o_res.last)
    `GRG_ASSERT_IMP(a_uni_zero, i_clk, i_rst_n,
        o_valid && o_res.uniform_value != 24'd0, o_res.normal_value == 32'd0)
    `GRG_ASSERT_IMP(a_busy_out, i_clk, i_rst_n, o_valid, busy)
endmodule
